/* hdl/pvbs_pkg.sv */
// shared constants, types and tables of the phase vocoder bin step
package pvbs_pkg;

    localparam int MaxFftSizeDefault = 8192;
    localparam logic [12:0] LastBinReset = 13'd2048;

    localparam logic OpSeed = 1'b0;
    localparam logic OpStep = 1'b1;

    localparam int CordicSteps = 20;
    localparam int SqrtSteps   = 24;
    localparam logic [16:0] WeightOne = 17'd65536;
    localparam logic [15:0] InvGainQ16 = 16'd39797;

    localparam int StgSquare   = 1;
    localparam int StgSum      = 2;
    localparam int StgAng0     = 2;
    localparam int StgAngRound = StgAng0 + CordicSteps;
    localparam int StgSqrt0    = 3;
    localparam int StgSqrtRnd  = StgSqrt0 + SqrtSteps;
    localparam int StgBlendMul = StgSqrtRnd + 1;
    localparam int StgBlendSum = StgBlendMul + 1;
    localparam int StgPhase    = StgBlendSum + 1;
    localparam int StgRotPrep  = StgPhase + 1;
    localparam int StgRot0     = StgRotPrep + 1;
    localparam int StgOut      = StgRot0 + CordicSteps;

    typedef struct packed {
        logic signed [35:0] x;
        logic signed [35:0] y;
        logic [23:0]        acc;
        logic               zero;
    } t_ang;

    typedef struct packed {
        logic [47:0] s;
        logic [27:0] rem;
        logic [23:0] q;
    } t_sqrt;

    typedef struct packed {
        logic               op;
        logic [12:0]        bin;
        logic signed [23:0] fre;
        logic signed [23:0] fim;
        logic signed [23:0] nre;
        logic signed [23:0] nim;
        logic [16:0]        w;
        logic [46:0]        sqa;
        logic [46:0]        sqb;
        logic [46:0]        sqc;
        logic [46:0]        sqd;
        t_ang               ang1;
        t_ang               ang2;
        logic [15:0]        a1;
        logic [15:0]        a2;
        t_sqrt              sq1;
        t_sqrt              sq2;
        logic [23:0]        m1;
        logic [23:0]        m2;
        logic [40:0]        p1;
        logic [40:0]        p2;
        logic [23:0]        mag;
        logic [1:0]         quad;
        logic signed [24:0] rz;
        logic signed [43:0] rx;
        logic signed [43:0] ry;
        logic [24:0]        ore;
        logic [24:0]        oim;
    } t_stage;

    function automatic logic [21:0] atan_turn(input int i);
        logic [21:0] v;
        case (i)
            0:  v = 22'd2097152;
            1:  v = 22'd1238021;
            2:  v = 22'd654136;
            3:  v = 22'd332050;
            4:  v = 22'd166669;
            5:  v = 22'd83416;
            6:  v = 22'd41718;
            7:  v = 22'd20860;
            8:  v = 22'd10430;
            9:  v = 22'd5215;
            10: v = 22'd2608;
            11: v = 22'd1304;
            12: v = 22'd652;
            13: v = 22'd326;
            14: v = 22'd163;
            15: v = 22'd81;
            16: v = 22'd41;
            17: v = 22'd20;
            18: v = 22'd10;
            19: v = 22'd5;
            default: v = 22'd0;
        endcase
        return v;
    endfunction

endpackage

/* hdl/phase_vocoder_bin_step.sv */
// phase vocoder bin step: pipelined angle, magnitude, blend, phase store and rotation
//
// input channel (s_axis): one beat per bin; tuser is the operation (0 seeds the
// stored phase from the angle of the first value, 1 runs a vocoder step)
// output channel (m_axis): one beat per step item; seed items and items whose
// bin lies beyond the phase store give no beat
// config: i_cfg_we writes i_cfg_wdata as the nyquist bin index; the user must write
// it only while idle (not enforced); throughput: one beat per cycle unless stalled;
// the phase store is read one stage ahead of its read-modify-write and a bypass
// covers the same bin in consecutive beats
// every stage holds its own valid bit, so bubbles close up when the receiver
// stalls and a full pipe holds every beat until o_m_axis_tvalid is taken
// reset clears all valid bits and sets the nyquist index to 2048; the phase
// store is not cleared, so a bin must be seeded before its first step
module phase_vocoder_bin_step #(
    parameter int MAX_FFT_SIZE = pvbs_pkg::MaxFftSizeDefault
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    // bin_index, first_re, first_im, next_re, next_im, blend_weight, zero pad
    input  logic [127:0] i_s_axis_tdata,
    // operation
    input  logic         i_s_axis_tuser,
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // out_bin, out_magnitude, out_re, out_im, zero pad
    output logic [87:0]  o_m_axis_tdata,
    input  logic         i_cfg_we,
    input  logic [12:0]  i_cfg_wdata
);

    localparam int NumBins = MAX_FFT_SIZE / 2 + 1;
    localparam int AddrW   = $clog2(NumBins);
    localparam int Last    = pvbs_pkg::StgOut;

    pvbs_pkg::t_stage r_st [Last+1];
    pvbs_pkg::t_stage n_st [Last+1];
    logic [Last:0]    r_v;
    logic [Last+1:0]  en;
    logic [12:0]      r_last_bin;
    logic [15:0]      r_phase_mem [NumBins];
    logic [15:0]      r_rd;
    logic             r_byp;
    logic [15:0]      r_byp_val;
    logic [15:0]      ph_cur;
    logic [15:0]      ph_new;
    logic             in_range;

    function automatic pvbs_pkg::t_ang ang_init(input logic signed [23:0] re,
                                                input logic signed [23:0] im);
        pvbs_pkg::t_ang a;
        a.x    = {{4{re[23]}}, re, 8'd0};
        a.y    = {{4{im[23]}}, im, 8'd0};
        a.acc  = 24'd0;
        a.zero = (re == 24'sd0) && (im == 24'sd0);
        if (re[23]) begin
            a.x   = -a.x;
            a.y   = -a.y;
            a.acc = 24'h800000;
        end
        return a;
    endfunction

    function automatic pvbs_pkg::t_ang ang_iter(input pvbs_pkg::t_ang a, input int i);
        pvbs_pkg::t_ang b;
        b = a;
        if (!a.y[35]) begin
            b.x   = a.x + (a.y >>> i);
            b.y   = a.y - (a.x >>> i);
            b.acc = a.acc + 24'(pvbs_pkg::atan_turn(i));
        end else begin
            b.x   = a.x - (a.y >>> i);
            b.y   = a.y + (a.x >>> i);
            b.acc = a.acc - 24'(pvbs_pkg::atan_turn(i));
        end
        return b;
    endfunction

    function automatic logic [15:0] ang_round(input pvbs_pkg::t_ang a);
        logic [23:0] t;
        t = a.acc + 24'd128;
        return a.zero ? 16'd0 : t[23:8];
    endfunction

    function automatic pvbs_pkg::t_sqrt sqrt_iter(input pvbs_pkg::t_sqrt a, input int i);
        pvbs_pkg::t_sqrt b;
        logic [27:0] rn;
        logic [27:0] t;
        b  = a;
        rn = {a.rem[25:0], a.s[2*i+1 -: 2]};
        t  = {2'b00, a.q, 2'b01};
        if (rn >= t) begin
            b.rem = rn - t;
            b.q   = {a.q[22:0], 1'b1};
        end else begin
            b.rem = rn;
            b.q   = {a.q[22:0], 1'b0};
        end
        return b;
    endfunction

    function automatic logic [24:0] round_sat(input logic signed [43:0] v);
        logic signed [44:0] s;
        logic signed [28:0] r;
        s = 45'(v) + 45'sd32768;
        r = 29'(s >>> 16);
        if (r > 29'sd16777215) begin
            return 25'h0FFFFFF;
        end else if (r < -29'sd16777216) begin
            return 25'h1000000;
        end
        return r[24:0];
    endfunction

    function automatic pvbs_pkg::t_stage stage_next(input pvbs_pkg::t_stage s, input int k,
                                                    input logic [15:0] ph,
                                                    input logic [12:0] last_bin);
        pvbs_pkg::t_stage n;
        logic signed [47:0] pa;
        logic signed [47:0] pb;
        logic signed [47:0] pc;
        logic signed [47:0] pd;
        logic [41:0]        bs;
        logic [25:0]        bm;
        logic [15:0]        t16;
        logic [15:0]        r16;
        logic [43:0]        xm;
        logic signed [43:0] fx;
        logic signed [43:0] fy;
        logic [24:0]        cs;
        n = s;
        if (k == pvbs_pkg::StgSquare) begin
            pa    = s.fre * s.fre;
            pb    = s.fim * s.fim;
            pc    = s.nre * s.nre;
            pd    = s.nim * s.nim;
            n.sqa = pa[46:0];
            n.sqb = pb[46:0];
            n.sqc = pc[46:0];
            n.sqd = pd[46:0];
            n.ang1 = ang_init(s.fre, s.fim);
            n.ang2 = ang_init(s.nre, s.nim);
        end
        if (k >= pvbs_pkg::StgAng0 && k < pvbs_pkg::StgAngRound) begin
            n.ang1 = ang_iter(s.ang1, k - pvbs_pkg::StgAng0);
            n.ang2 = ang_iter(s.ang2, k - pvbs_pkg::StgAng0);
        end
        if (k == pvbs_pkg::StgAngRound) begin
            n.a1 = ang_round(s.ang1);
            n.a2 = ang_round(s.ang2);
        end
        if (k == pvbs_pkg::StgSum) begin
            n.sq1.s   = 48'(s.sqa) + 48'(s.sqb);
            n.sq2.s   = 48'(s.sqc) + 48'(s.sqd);
            n.sq1.rem = '0;
            n.sq1.q   = '0;
            n.sq2.rem = '0;
            n.sq2.q   = '0;
        end
        if (k >= pvbs_pkg::StgSqrt0 && k < pvbs_pkg::StgSqrtRnd) begin
            n.sq1 = sqrt_iter(s.sq1, pvbs_pkg::SqrtSteps - 1 - (k - pvbs_pkg::StgSqrt0));
            n.sq2 = sqrt_iter(s.sq2, pvbs_pkg::SqrtSteps - 1 - (k - pvbs_pkg::StgSqrt0));
        end
        if (k == pvbs_pkg::StgSqrtRnd) begin
            n.m1 = (s.sq1.rem > 28'(s.sq1.q)) ? s.sq1.q + 24'd1 : s.sq1.q;
            n.m2 = (s.sq2.rem > 28'(s.sq2.q)) ? s.sq2.q + 24'd1 : s.sq2.q;
        end
        if (k == pvbs_pkg::StgBlendMul) begin
            n.p1 = 41'(s.m1) * 41'(pvbs_pkg::WeightOne - s.w);
            n.p2 = 41'(s.m2) * 41'(s.w);
        end
        if (k == pvbs_pkg::StgBlendSum) begin
            bs    = 42'(s.p1) + 42'(s.p2) + 42'd32768;
            bm    = bs[41:16];
            n.mag = (bm > 26'd16777215) ? 24'hFFFFFF : bm[23:0];
        end
        if (k == pvbs_pkg::StgRotPrep) begin
            t16    = ph + 16'h2000;
            n.quad = t16[15:14];
            r16    = ph - {t16[15:14], 14'd0};
            n.rz   = {r16[15], r16, 8'd0};
            xm     = 44'(s.mag) * 44'(pvbs_pkg::InvGainQ16);
            n.rx   = xm;
            n.ry   = '0;
        end
        if (k >= pvbs_pkg::StgRot0 && k < pvbs_pkg::StgOut) begin
            if (!s.rz[24]) begin
                n.rx = s.rx - (s.ry >>> (k - pvbs_pkg::StgRot0));
                n.ry = s.ry + (s.rx >>> (k - pvbs_pkg::StgRot0));
                n.rz = s.rz - 25'(pvbs_pkg::atan_turn(k - pvbs_pkg::StgRot0));
            end else begin
                n.rx = s.rx + (s.ry >>> (k - pvbs_pkg::StgRot0));
                n.ry = s.ry - (s.rx >>> (k - pvbs_pkg::StgRot0));
                n.rz = s.rz + 25'(pvbs_pkg::atan_turn(k - pvbs_pkg::StgRot0));
            end
        end
        if (k == pvbs_pkg::StgOut) begin
            case (s.quad)
                2'd0: begin
                    fx = s.rx;
                    fy = s.ry;
                end
                2'd1: begin
                    fx = -s.ry;
                    fy = s.rx;
                end
                2'd2: begin
                    fx = -s.rx;
                    fy = -s.ry;
                end
                default: begin
                    fx = s.ry;
                    fy = -s.rx;
                end
            endcase
            cs = round_sat(fx);
            if (s.bin == 13'd0 || s.bin == last_bin) begin
                n.ore = cs[24] ? 25'd0 - {1'b0, s.mag} : {1'b0, s.mag};
                n.oim = '0;
            end else begin
                n.ore = cs;
                n.oim = round_sat(fy);
            end
        end
        return n;
    endfunction

    assign in_range = 32'(i_s_axis_tdata[12:0]) < NumBins;

    always_comb begin
        en[Last+1] = i_m_axis_tready;
        for (int k = Last; k >= 0; k--) begin
            en[k] = !r_v[k] || en[k+1];
        end
    end

    assign o_s_axis_tready = en[0];

    assign ph_cur = r_byp ? r_byp_val : r_rd;
    assign ph_new = (r_st[pvbs_pkg::StgPhase].op == pvbs_pkg::OpStep)
                  ? 16'(ph_cur + r_st[pvbs_pkg::StgPhase].a2 - r_st[pvbs_pkg::StgPhase].a1)
                  : r_st[pvbs_pkg::StgPhase].a1;

    always_comb begin
        n_st[0].op  = i_s_axis_tuser;
        n_st[0]     = r_st[0];
        n_st[0].op  = i_s_axis_tuser;
        n_st[0].bin = i_s_axis_tdata[12:0];
        n_st[0].fre = i_s_axis_tdata[36:13];
        n_st[0].fim = i_s_axis_tdata[60:37];
        n_st[0].nre = i_s_axis_tdata[84:61];
        n_st[0].nim = i_s_axis_tdata[108:85];
        n_st[0].w   = (i_s_axis_tdata[125:109] > pvbs_pkg::WeightOne)
                    ? pvbs_pkg::WeightOne : i_s_axis_tdata[125:109];
        for (int k = 1; k <= Last; k++) begin
            n_st[k] = stage_next(r_st[k-1], k, ph_cur, r_last_bin);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v        <= '0;
            r_last_bin <= pvbs_pkg::LastBinReset;
        end else begin
            if (i_cfg_we) begin
                r_last_bin <= i_cfg_wdata;
            end
            if (en[0]) begin
                r_v[0] <= i_s_axis_tvalid && in_range;
            end
            for (int k = 1; k <= Last; k++) begin
                if (en[k]) begin
                    if (k == pvbs_pkg::StgRotPrep) begin
                        r_v[k] <= r_v[k-1] && (r_st[k-1].op == pvbs_pkg::OpStep);
                    end else begin
                        r_v[k] <= r_v[k-1];
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k <= Last; k++) begin
            if (en[k]) begin
                r_st[k] <= n_st[k];
            end
        end
    end

    // phase store: read as a beat enters the phase stage, written as it leaves
    always_ff @(posedge i_clk) begin
        if (r_v[pvbs_pkg::StgPhase] && en[pvbs_pkg::StgPhase+1]) begin
            r_phase_mem[AddrW'(r_st[pvbs_pkg::StgPhase].bin)] <= ph_new;
        end
        if (en[pvbs_pkg::StgPhase]) begin
            r_rd      <= r_phase_mem[AddrW'(r_st[pvbs_pkg::StgPhase-1].bin)];
            r_byp     <= r_v[pvbs_pkg::StgPhase] && en[pvbs_pkg::StgPhase+1]
                         && (r_st[pvbs_pkg::StgPhase].bin == r_st[pvbs_pkg::StgPhase-1].bin);
            r_byp_val <= ph_new;
        end
    end

    assign o_m_axis_tvalid = r_v[Last];
    assign o_m_axis_tdata  = {1'b0, r_st[Last].oim, r_st[Last].ore,
                              r_st[Last].mag, r_st[Last].bin};

endmodule
